// ===== sv/lfpd_pkg.sv =====
package lfpd_pkg;

  localparam int LEVEL_W    = 7;
  localparam int GAIN_W     = 24;
  localparam int DIST_W     = 16;
  localparam int POWER_W    = 8;
  localparam int PAT_W      = 4;
  localparam int ERR_W      = 8;
  localparam int INT_W      = 11;
  localparam int DIFF_W     = 9;
  localparam int U_W        = 25;
  localparam int MUL_A_W    = 26;
  localparam int MUL_B_W    = 16;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 38;
  localparam int Q1_W       = 15;
  localparam int QUO_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [LEVEL_W-1:0] BLACK_MAX    = 7'd40;
  localparam logic [LEVEL_W-1:0] LEVEL_WHITE  = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_BLACK  = 7'd0;
  localparam logic [LEVEL_W-1:0] POWER_LIMIT  = 7'd100;
  localparam logic [PAT_W-1:0]   PAT_WB       = 4'd4;
  localparam logic [PAT_W-1:0]   PAT_BW       = 4'd1;
  localparam logic [PAT_W-1:0]   PAT_WW       = 4'd5;
  localparam logic signed [INT_W-1:0] INT2_LIMIT = 11'sd1000;
  localparam int OUT_LIMIT = 13107200;
  // floor(q / 100) == (q * 5243) >> 19 for every q below 2^15.
  localparam logic [MUL_B_W-1:0] RECIP_100 = 16'd5243;
  localparam int RECIP_SHIFT = 19;
  localparam int POWER_SHIFT = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_LEVEL  = 3'd0,
    REG_KP_INNER      = 3'd1,
    REG_KP_OUTER      = 3'd2,
    REG_KI            = 3'd3,
    REG_KD            = 3'd4,
    REG_BASE_POWER    = 3'd5,
    REG_SPEED_SPAN    = 3'd6,
    REG_HALT_RANGE    = 3'd7
  } lfpd_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_CLAMP,
    ST_MUL_SPAN,
    ST_NUM,
    ST_DIV_L,
    ST_DIV_R,
    ST_FIN,
    ST_WRITE
  } lfpd_state_e;

  typedef struct packed {
    lfpd_state_e state;
    logic        in_ready;
    logic        mul_en;
    logic        out_load;
  } lfpd_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic stop_hit;
    logic out_free;
  } lfpd_stat_t;

endpackage

// ===== sv/lfpd_if.sv =====
interface lfpd_in_if;
  logic                               valid;
  logic                               ready;
  logic [lfpd_pkg::LEVEL_W-1:0]       left_level;
  logic [lfpd_pkg::LEVEL_W-1:0]       right_level;
  logic [lfpd_pkg::DIST_W-1:0]        distance;

  modport source (output valid, left_level, right_level, distance, input ready);
  modport sink   (input valid, left_level, right_level, distance, output ready);
endinterface

interface lfpd_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lfpd_pkg::POWER_W-1:0] left_power;
  logic signed [lfpd_pkg::POWER_W-1:0] right_power;
  logic                               stopped;
  logic [lfpd_pkg::PAT_W-1:0]         pattern;

  modport source (output valid, left_power, right_power, stopped, pattern, input ready);
  modport sink   (input valid, left_power, right_power, stopped, pattern, output ready);
endinterface

// ===== sv/lfpd_mul.sv =====
module lfpd_mul (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [lfpd_pkg::MUL_A_W-1:0]   a_i,
  input  logic signed [lfpd_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [lfpd_pkg::PROD_W-1:0]    prod_o
);

  logic signed [lfpd_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/lfpd_seq.sv =====
module lfpd_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfpd_pkg::lfpd_stat_t stat_i,
  output lfpd_pkg::lfpd_ctrl_t ctrl_o
);

  lfpd_pkg::lfpd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfpd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ctrl_o.state    = state_q;
    ctrl_o.in_ready = 1'b0;
    ctrl_o.mul_en   = 1'b0;
    ctrl_o.out_load = 1'b0;
    unique case (state_q)
      lfpd_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_valid) state_d = lfpd_pkg::ST_EVAL;
      end
      lfpd_pkg::ST_EVAL: begin
        state_d = stat_i.stop_hit ? lfpd_pkg::ST_WRITE : lfpd_pkg::ST_MUL_P;
      end
      lfpd_pkg::ST_MUL_P: begin
        ctrl_o.mul_en = 1'b1;
        state_d = lfpd_pkg::ST_MUL_I;
      end
      lfpd_pkg::ST_MUL_I: begin
        ctrl_o.mul_en = 1'b1;
        state_d = lfpd_pkg::ST_MUL_D;
      end
      lfpd_pkg::ST_MUL_D: begin
        ctrl_o.mul_en = 1'b1;
        state_d = lfpd_pkg::ST_ACC;
      end
      lfpd_pkg::ST_ACC:   state_d = lfpd_pkg::ST_CLAMP;
      lfpd_pkg::ST_CLAMP: state_d = lfpd_pkg::ST_MUL_SPAN;
      lfpd_pkg::ST_MUL_SPAN: begin
        ctrl_o.mul_en = 1'b1;
        state_d = lfpd_pkg::ST_NUM;
      end
      lfpd_pkg::ST_NUM: state_d = lfpd_pkg::ST_DIV_L;
      lfpd_pkg::ST_DIV_L: begin
        ctrl_o.mul_en = 1'b1;
        state_d = lfpd_pkg::ST_DIV_R;
      end
      lfpd_pkg::ST_DIV_R: begin
        ctrl_o.mul_en = 1'b1;
        state_d = lfpd_pkg::ST_FIN;
      end
      lfpd_pkg::ST_FIN: state_d = lfpd_pkg::ST_WRITE;
      lfpd_pkg::ST_WRITE: begin
        ctrl_o.out_load = stat_i.out_free;
        if (stat_i.out_free) state_d = lfpd_pkg::ST_IDLE;
      end
      default: state_d = lfpd_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/line_follow_pid_drive_top.sv =====
// PID line follower drive. One sample beat is taken at a time: a driving
// sample passes every state to the write, a stopped one (distance below the
// stop threshold) skips from evaluation to the write. The single shared 26x16
// multiplier is used six times per sample in turn: the P, I and D terms, the
// span scaling of the controller output, and the reciprocal divide by 100 for
// each wheel. A finished result sits in an output register, so a new sample
// is taken while the result waits. Gains are unsigned with 16 fraction bits;
// the user writes configuration only while idle; the block does not check it.
module line_follow_pid_drive_top #(
  parameter int SAMPLES_PER_GENERATION = 100,
  parameter int EDGE_HOLD_GENERATIONS  = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  lfpd_in_if.sink                           in_i,
  lfpd_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int HoldLimit = SAMPLES_PER_GENERATION * (EDGE_HOLD_GENERATIONS + 1);
  localparam int CntW      = $clog2(HoldLimit + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(HoldLimit);
  localparam logic signed [lfpd_pkg::ACC_W-1:0] OutHi = lfpd_pkg::ACC_W'(lfpd_pkg::OUT_LIMIT);
  localparam logic signed [lfpd_pkg::ACC_W-1:0] OutLo = -OutHi;
  localparam logic signed [lfpd_pkg::INT_W:0] IntHi =
    {lfpd_pkg::INT2_LIMIT[lfpd_pkg::INT_W-1], lfpd_pkg::INT2_LIMIT};
  localparam logic signed [lfpd_pkg::INT_W:0] IntLo = -IntHi;

  // Configuration registers.
  logic [lfpd_pkg::LEVEL_W-1:0] target_q, base_q, span_q;
  logic [lfpd_pkg::GAIN_W-1:0]  kp_inner_q, kp_outer_q, ki_q, kd_q;
  logic [lfpd_pkg::DIST_W-1:0]  stop_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= 7'd60;
      kp_inner_q  <= 24'd26214;
      kp_outer_q  <= 24'd1311;
      ki_q        <= 24'd66;
      kd_q        <= 24'd85197;
      base_q      <= 7'd38;
      span_q      <= 7'd38;
      stop_dist_q <= 16'd150;
    end else if (cfg_we_i) begin
      unique case (lfpd_pkg::lfpd_reg_e'(cfg_idx_i))
        lfpd_pkg::REG_TARGET_LEVEL:  target_q    <= cfg_data_i[lfpd_pkg::LEVEL_W-1:0];
        lfpd_pkg::REG_KP_INNER:      kp_inner_q  <= cfg_data_i;
        lfpd_pkg::REG_KP_OUTER:      kp_outer_q  <= cfg_data_i;
        lfpd_pkg::REG_KI:            ki_q        <= cfg_data_i;
        lfpd_pkg::REG_KD:            kd_q        <= cfg_data_i;
        lfpd_pkg::REG_BASE_POWER:    base_q      <= cfg_data_i[lfpd_pkg::LEVEL_W-1:0];
        lfpd_pkg::REG_SPEED_SPAN:    span_q      <= cfg_data_i[lfpd_pkg::LEVEL_W-1:0];
        lfpd_pkg::REG_HALT_RANGE:    stop_dist_q <= cfg_data_i[lfpd_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  lfpd_pkg::lfpd_ctrl_t ctrl;
  lfpd_pkg::lfpd_stat_t stat;

  logic in_beat;
  assign in_beat = in_i.valid && in_i.ready;

  // Sample latch.
  logic [lfpd_pkg::LEVEL_W-1:0] left_q, right_q;
  logic [lfpd_pkg::DIST_W-1:0]  dist_q;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      left_q  <= in_i.left_level;
      right_q <= in_i.right_level;
      dist_q  <= in_i.distance;
    end
  end

  // Controller state.
  logic signed [lfpd_pkg::ERR_W-1:0] prev_err_q;
  logic signed [lfpd_pkg::INT_W-1:0] int_q;
  logic [lfpd_pkg::PAT_W-1:0]        prev_pat_q, last_pat_q;
  logic                              osel_q;
  logic [CntW-1:0]                   cnt_q;

  // Per-sample working registers.
  logic                               stop_q, brake_half_q, brake_3q_q;
  logic signed [lfpd_pkg::DIFF_W-1:0] diff_q;
  logic signed [lfpd_pkg::ACC_W-1:0]  acc_q;
  logic signed [lfpd_pkg::U_W-1:0]    u_q;
  logic [lfpd_pkg::Q1_W-1:0]          q1l_q, q1r_q;
  logic                               negl_q, negr_q;
  logic [lfpd_pkg::POWER_W-1:0]       lp_q, rp_q;

  // Sample evaluation.
  logic                               stop_hit, brake_half, brake_3q;
  logic [CntW-1:0]                    cnt_next;
  logic [lfpd_pkg::PAT_W-1:0]         pat_now, last_next;
  logic                               pat_chg, osel_next;
  logic [lfpd_pkg::LEVEL_W-1:0]       eff_left;
  logic signed [lfpd_pkg::ERR_W-1:0]  e_now;
  logic signed [lfpd_pkg::INT_W:0]    i2_sum;
  logic signed [lfpd_pkg::INT_W-1:0]  i2_clamp;
  logic signed [lfpd_pkg::DIFF_W-1:0] diff_now;

  always_comb begin
    stop_hit   = dist_q < stop_dist_q;
    brake_half = {1'b0, dist_q} < {stop_dist_q, 1'b0};
    brake_3q   = {2'b0, dist_q} < {stop_dist_q, 2'b0};
    cnt_next   = (cnt_q < CntMax) ? cnt_q + CntW'(1) : cnt_q;
    pat_now    = {1'b0, left_q > lfpd_pkg::BLACK_MAX, 1'b0, right_q > lfpd_pkg::BLACK_MAX};
    pat_chg    = pat_now != prev_pat_q;
    last_next  = pat_chg ? prev_pat_q : last_pat_q;
    osel_next  = pat_chg ? (pat_now == lfpd_pkg::PAT_WW) : osel_q;
    eff_left   = left_q;
    // Lost line after the warm-up: steer back toward the side it was left on.
    if (cnt_next == CntMax && pat_now == lfpd_pkg::PAT_WW) begin
      if (last_next == lfpd_pkg::PAT_WB) begin
        eff_left = lfpd_pkg::LEVEL_WHITE;
      end else if (last_next == lfpd_pkg::PAT_BW) begin
        eff_left = lfpd_pkg::LEVEL_BLACK;
      end
    end
    e_now    = $signed({1'b0, eff_left} - {1'b0, target_q});
    i2_sum   = $signed({int_q[lfpd_pkg::INT_W-1], int_q})
             + $signed({{4{prev_err_q[lfpd_pkg::ERR_W-1]}}, prev_err_q})
             + $signed({{4{e_now[lfpd_pkg::ERR_W-1]}}, e_now});
    if (i2_sum > IntHi) begin
      i2_clamp = lfpd_pkg::INT2_LIMIT;
    end else if (i2_sum < IntLo) begin
      i2_clamp = -lfpd_pkg::INT2_LIMIT;
    end else begin
      i2_clamp = i2_sum[lfpd_pkg::INT_W-1:0];
    end
    diff_now = $signed({e_now[lfpd_pkg::ERR_W-1], e_now})
             - $signed({prev_err_q[lfpd_pkg::ERR_W-1], prev_err_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      int_q      <= '0;
      prev_pat_q <= '0;
      last_pat_q <= '0;
      osel_q     <= 1'b0;
      cnt_q      <= '0;
    end else if (ctrl.state == lfpd_pkg::ST_EVAL && !stop_hit) begin
      prev_err_q <= e_now;
      int_q      <= i2_clamp;
      prev_pat_q <= pat_now;
      last_pat_q <= last_next;
      osel_q     <= osel_next;
      cnt_q      <= cnt_next;
    end
  end

  // Shared multiplier and its operand select.
  logic signed [lfpd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lfpd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [lfpd_pkg::PROD_W-1:0]  prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.state)
      lfpd_pkg::ST_MUL_P: begin
        mul_a = $signed({2'b0, osel_q ? kp_outer_q : kp_inner_q});
        mul_b = $signed({{8{prev_err_q[lfpd_pkg::ERR_W-1]}}, prev_err_q});
      end
      lfpd_pkg::ST_MUL_I: begin
        mul_a = $signed({2'b0, ki_q});
        mul_b = $signed({{5{int_q[lfpd_pkg::INT_W-1]}}, int_q});
      end
      lfpd_pkg::ST_MUL_D: begin
        mul_a = $signed({2'b0, kd_q});
        mul_b = $signed({{7{diff_q[lfpd_pkg::DIFF_W-1]}}, diff_q});
      end
      lfpd_pkg::ST_MUL_SPAN: begin
        mul_a = $signed({u_q[lfpd_pkg::U_W-1], u_q});
        mul_b = $signed({9'b0, span_q});
      end
      lfpd_pkg::ST_DIV_L: begin
        mul_a = $signed({11'b0, q1l_q});
        mul_b = $signed(lfpd_pkg::RECIP_100);
      end
      lfpd_pkg::ST_DIV_R: begin
        mul_a = $signed({11'b0, q1r_q});
        mul_b = $signed(lfpd_pkg::RECIP_100);
      end
      default: ;
    endcase
  end

  lfpd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Wheel power numerators: base * 100 * 2^17 plus or minus u * span.
  logic [13:0]         base100;
  logic signed [33:0]  base_num, us_ext, nl, nr;
  logic [33:0]         magl, magr;

  always_comb begin
    base100  = {1'b0, base_q, 6'b0} + {2'b0, base_q, 5'b0} + {5'b0, base_q, 2'b0};
    base_num = $signed({3'b0, base100, 17'b0});
    us_ext   = $signed({{2{prod[31]}}, prod[31:0]});
    nl       = base_num + us_ext;
    nr       = base_num - us_ext;
    magl     = nl[33] ? 34'(-nl) : nl;
    magr     = nr[33] ? 34'(-nr) : nr;
  end

  // Saturate the quotient, brake toward zero on the magnitude, then apply sign.
  function automatic logic [lfpd_pkg::POWER_W-1:0] drive_power(
    logic [lfpd_pkg::QUO_W-1:0] quo,
    logic                       neg,
    logic                       half,
    logic                       three_q
  );
    logic [6:0] mag;
    logic [8:0] mag3;
    logic [6:0] braked;
    mag  = (quo > {2'b0, lfpd_pkg::POWER_LIMIT}) ? lfpd_pkg::POWER_LIMIT : quo[6:0];
    mag3 = {2'b0, mag} + {1'b0, mag, 1'b0};
    if (half) begin
      braked = {1'b0, mag[6:1]};
    end else if (three_q) begin
      braked = mag3[8:2];
    end else begin
      braked = mag;
    end
    return neg ? 8'(-{1'b0, braked}) : {1'b0, braked};
  endfunction

  logic [lfpd_pkg::QUO_W-1:0] quo;
  assign quo = prod[lfpd_pkg::RECIP_SHIFT+lfpd_pkg::QUO_W-1:lfpd_pkg::RECIP_SHIFT];

  always_ff @(posedge clk_i) begin
    unique case (ctrl.state)
      lfpd_pkg::ST_EVAL: begin
        stop_q       <= stop_hit;
        brake_half_q <= brake_half;
        brake_3q_q   <= brake_3q;
        diff_q       <= diff_now;
      end
      lfpd_pkg::ST_MUL_I: acc_q <= $signed({prod[lfpd_pkg::ACC_W-2:0], 1'b0});
      lfpd_pkg::ST_MUL_D: acc_q <= acc_q + $signed(prod[lfpd_pkg::ACC_W-1:0]);
      lfpd_pkg::ST_ACC:   acc_q <= acc_q + $signed({prod[lfpd_pkg::ACC_W-2:0], 1'b0});
      lfpd_pkg::ST_CLAMP: begin
        if (acc_q > OutHi) begin
          u_q <= OutHi[lfpd_pkg::U_W-1:0];
        end else if (acc_q < OutLo) begin
          u_q <= OutLo[lfpd_pkg::U_W-1:0];
        end else begin
          u_q <= acc_q[lfpd_pkg::U_W-1:0];
        end
      end
      lfpd_pkg::ST_NUM: begin
        q1l_q  <= magl[lfpd_pkg::POWER_SHIFT+lfpd_pkg::Q1_W-1:lfpd_pkg::POWER_SHIFT];
        q1r_q  <= magr[lfpd_pkg::POWER_SHIFT+lfpd_pkg::Q1_W-1:lfpd_pkg::POWER_SHIFT];
        negl_q <= nl[33];
        negr_q <= nr[33];
      end
      lfpd_pkg::ST_DIV_R: lp_q <= drive_power(quo, negl_q, brake_half_q, brake_3q_q);
      lfpd_pkg::ST_FIN:   rp_q <= drive_power(quo, negr_q, brake_half_q, brake_3q_q);
      default: ;
    endcase
  end

  // Output register.
  logic                         out_valid_q;
  logic [lfpd_pkg::POWER_W-1:0] lp_res_q, rp_res_q;
  logic                         stop_res_q;
  logic [lfpd_pkg::PAT_W-1:0]   pat_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      lp_res_q   <= stop_q ? '0 : lp_q;
      rp_res_q   <= stop_q ? '0 : rp_q;
      stop_res_q <= stop_q;
      pat_res_q  <= stop_q ? '0 : prev_pat_q;
    end
  end

  assign stat.in_valid = in_i.valid;
  assign stat.stop_hit = stop_hit;
  assign stat.out_free = !out_valid_q || out_o.ready;

  lfpd_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign in_i.ready        = ctrl.in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.left_power  = $signed(lp_res_q);
  assign out_o.right_power = $signed(rp_res_q);
  assign out_o.stopped     = stop_res_q;
  assign out_o.pattern     = pat_res_q;

  a_accept_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> ctrl.state == lfpd_pkg::ST_EVAL)
    else $error("accepted sample beat did not start evaluation");

  a_integral_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int_q <= lfpd_pkg::INT2_LIMIT && int_q >= -lfpd_pkg::INT2_LIMIT)
    else $error("integral left its clamp range");

  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.stopped) |->
      (out_o.left_power == 0 && out_o.right_power == 0 && out_o.pattern == 0))
    else $error("stopped result carries nonzero fields");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.left_power <= 8'sd100 && out_o.left_power >= -8'sd100 &&
                     out_o.right_power <= 8'sd100 && out_o.right_power >= -8'sd100))
    else $error("wheel power out of range");

endmodule

// ===== test/line_follow_pid_drive_top_tb.sv =====
module line_follow_pid_drive_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLES_PER_GENERATION = 100;
  localparam int EDGE_HOLD_GENERATIONS  = 3;
  localparam int HOLD_LIMIT   = SAMPLES_PER_GENERATION * (EDGE_HOLD_GENERATIONS + 1);
  localparam longint POWER_DEN = 100 * (longint'(1) << lfpd_pkg::POWER_SHIFT);
  localparam longint POWER_MAX = longint'(lfpd_pkg::POWER_LIMIT);
  localparam int ITEMS_PER_PHASE = 143;
  localparam int IDLE_SETTLE     = 20;
  localparam int CYCLE_LIMIT     = 1000000;

  typedef enum int {BRAKE_NONE, BRAKE_HALF, BRAKE_THREE_Q} brake_e;
  typedef enum int {SET_DEFAULT, SET_TUNED, SET_MIN, SET_MAX, SET_WILD, SET_SATURATE}
    setting_kind_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_STALLS} rx_mode_e;

  typedef struct packed {
    logic signed [lfpd_pkg::POWER_W-1:0] left_power;
    logic signed [lfpd_pkg::POWER_W-1:0] right_power;
    logic                                stopped;
    logic [lfpd_pkg::PAT_W-1:0]          pattern;
  } drive_result_t;

  class pid_drive_scoreboard;
    logic [lfpd_pkg::LEVEL_W-1:0] target_level, cruise_power, speed_span;
    logic [lfpd_pkg::GAIN_W-1:0]  kp_inner, kp_outer, ki, kd;
    logic [lfpd_pkg::DIST_W-1:0]  halt_range;

    int                         prev_error, integral2, sample_count;
    logic [lfpd_pkg::PAT_W-1:0] prev_pattern, last_pattern;
    bit                         outer_sel;

    drive_result_t expected_drive_q[$];
    int errors, checked, n_stopped, n_half, n_three_q, n_edge_hold, n_outer;

    function new();
      target_level  = 7'd60;
      kp_inner      = 24'd26214;
      kp_outer      = 24'd1311;
      ki            = 24'd66;
      kd            = 24'd85197;
      cruise_power  = 7'd38;
      speed_span    = 7'd38;
      halt_range    = 16'd150;
      prev_error    = 0;
      integral2     = 0;
      sample_count  = 0;
      prev_pattern  = '0;
      last_pattern  = '0;
      outer_sel     = 1'b0;
    endfunction

    function void set_reg(lfpd_pkg::lfpd_reg_e idx, logic [lfpd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lfpd_pkg::REG_TARGET_LEVEL: target_level = data[lfpd_pkg::LEVEL_W-1:0];
        lfpd_pkg::REG_KP_INNER:     kp_inner     = data;
        lfpd_pkg::REG_KP_OUTER:     kp_outer     = data;
        lfpd_pkg::REG_KI:           ki           = data;
        lfpd_pkg::REG_KD:           kd           = data;
        lfpd_pkg::REG_BASE_POWER:   cruise_power = data[lfpd_pkg::LEVEL_W-1:0];
        lfpd_pkg::REG_SPEED_SPAN:   speed_span   = data[lfpd_pkg::LEVEL_W-1:0];
        lfpd_pkg::REG_HALT_RANGE:   halt_range   = data[lfpd_pkg::DIST_W-1:0];
        default: ;
      endcase
    endfunction

    function longint saturate_and_brake(longint p, brake_e mode);
      if (p > POWER_MAX) p = POWER_MAX;
      if (p < -POWER_MAX) p = -POWER_MAX;
      if (mode == BRAKE_HALF) return p / 2;
      if (mode == BRAKE_THREE_Q) return (p * 3) / 4;
      return p;
    endfunction

    function drive_result_t predict_drive(logic [lfpd_pkg::LEVEL_W-1:0] left_lvl,
                                          logic [lfpd_pkg::LEVEL_W-1:0] right_lvl,
                                          logic [lfpd_pkg::DIST_W-1:0]  obstacle);
      drive_result_t              res;
      brake_e                     mode;
      logic [lfpd_pkg::PAT_W-1:0] pat;
      int                         dist_v, stop_v, level, err, integ;
      longint                     gain, k_i, k_d, base_v, span_v, u, lp, rp;

      dist_v = int'(obstacle);
      stop_v = int'(halt_range);
      res = '0;
      if (dist_v < stop_v) begin
        res.stopped = 1'b1;
        n_stopped++;
        return res;
      end
      if (dist_v < 2 * stop_v) begin
        mode = BRAKE_HALF;
        n_half++;
      end else if (dist_v < 4 * stop_v) begin
        mode = BRAKE_THREE_Q;
        n_three_q++;
      end else begin
        mode = BRAKE_NONE;
      end

      if (sample_count < HOLD_LIMIT) sample_count++;

      pat = {1'b0, left_lvl > lfpd_pkg::BLACK_MAX, 1'b0, right_lvl > lfpd_pkg::BLACK_MAX};
      if (pat != prev_pattern) begin
        last_pattern = prev_pattern;
        outer_sel    = (pat == lfpd_pkg::PAT_WW);
      end

      // Once the hold window has passed, losing the line on both sides steers
      // back toward the side on which it was last seen.
      level = int'(left_lvl);
      if (sample_count >= HOLD_LIMIT && pat == lfpd_pkg::PAT_WW) begin
        if (last_pattern == lfpd_pkg::PAT_WB) begin
          level = int'(lfpd_pkg::LEVEL_WHITE);
          n_edge_hold++;
        end else if (last_pattern == lfpd_pkg::PAT_BW) begin
          level = int'(lfpd_pkg::LEVEL_BLACK);
          n_edge_hold++;
        end
      end

      err   = level - int'(target_level);
      integ = integral2 + prev_error + err;
      if (integ > lfpd_pkg::INT2_LIMIT) integ = int'(lfpd_pkg::INT2_LIMIT);
      if (integ < -lfpd_pkg::INT2_LIMIT) integ = -int'(lfpd_pkg::INT2_LIMIT);

      if (outer_sel) n_outer++;
      gain = outer_sel ? longint'(kp_outer) : longint'(kp_inner);
      k_i  = longint'(ki);
      k_d  = longint'(kd);
      u = 2 * gain * err + k_i * integ + 2 * k_d * (err - prev_error);
      if (u > lfpd_pkg::OUT_LIMIT) u = lfpd_pkg::OUT_LIMIT;
      if (u < -lfpd_pkg::OUT_LIMIT) u = -lfpd_pkg::OUT_LIMIT;
      integral2  = integ;
      prev_error = err;

      base_v = longint'(cruise_power);
      span_v = longint'(speed_span);
      lp = (base_v * POWER_DEN + u * span_v) / POWER_DEN;
      rp = (base_v * POWER_DEN - u * span_v) / POWER_DEN;
      res.left_power  = lfpd_pkg::POWER_W'(saturate_and_brake(lp, mode));
      res.right_power = lfpd_pkg::POWER_W'(saturate_and_brake(rp, mode));
      res.pattern     = pat;
      prev_pattern    = pat;
      return res;
    endfunction

    function void note_sample(logic [lfpd_pkg::LEVEL_W-1:0] left_lvl,
                              logic [lfpd_pkg::LEVEL_W-1:0] right_lvl,
                              logic [lfpd_pkg::DIST_W-1:0]  obstacle);
      expected_drive_q.push_back(predict_drive(left_lvl, right_lvl, obstacle));
    endfunction

    function void check_result(drive_result_t got);
      drive_result_t want;
      if (expected_drive_q.size() == 0) begin
        $error("Drive result with no sample waiting: left_power %0d right_power %0d",
               got.left_power, got.right_power);
        errors++;
        return;
      end
      want = expected_drive_q.pop_front();
      checked++;
      if (got.left_power !== want.left_power) begin
        $error("left_power: expected %0d, actual %0d", want.left_power, got.left_power);
        errors++;
      end
      if (got.right_power !== want.right_power) begin
        $error("right_power: expected %0d, actual %0d", want.right_power, got.right_power);
        errors++;
      end
      if (got.stopped !== want.stopped) begin
        $error("stopped: expected %0b, actual %0b", want.stopped, got.stopped);
        errors++;
      end
      if (got.pattern !== want.pattern) begin
        $error("pattern: expected %0d, actual %0d", want.pattern, got.pattern);
        errors++;
      end
    endfunction

    function int pending();
      return expected_drive_q.size();
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data;

  lfpd_in_if  in_bus ();
  lfpd_out_if out_bus ();

  pid_drive_scoreboard sb = new();

  int       cycle_count   = 0;
  int       burst_left    = 0;
  int       n_settings    = 1;
  rx_mode_e rx_mode       = RX_OPEN;
  int       rx_mode_left  = 0;
  int       rx_stall_left = 0;

  setting_kind_e phase_plan [10] = '{SET_DEFAULT, SET_TUNED, SET_MIN, SET_TUNED, SET_MAX,
                                     SET_WILD, SET_SATURATE, SET_TUNED, SET_WILD,
                                     SET_DEFAULT};

  line_follow_pid_drive_top #(
    .SAMPLES_PER_GENERATION (SAMPLES_PER_GENERATION),
    .EDGE_HOLD_GENERATIONS  (EDGE_HOLD_GENERATIONS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      sb.check_result('{out_bus.left_power, out_bus.right_power, out_bus.stopped,
                        out_bus.pattern});
    end
  end

  // The receiver cycles through always-ready, coin-flip and long-stall modes.
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = int'($urandom_range(50, 300));
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN: out_bus.ready <= 1'b1;
      RX_COIN: out_bus.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          out_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          rx_stall_left = int'($urandom_range(1, 25));
          out_bus.ready <= 1'b0;
        end else begin
          out_bus.ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_sample(input logic [lfpd_pkg::LEVEL_W-1:0] left_lvl,
                             input logic [lfpd_pkg::LEVEL_W-1:0] right_lvl,
                             input logic [lfpd_pkg::DIST_W-1:0]  obstacle);
    in_bus.valid       <= 1'b1;
    in_bus.left_level  <= left_lvl;
    in_bus.right_level <= right_lvl;
    in_bus.distance    <= obstacle;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_sample(left_lvl, right_lvl, obstacle);
    @(negedge clk_i);
  endtask

  task automatic hold_until_empty();
    in_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input lfpd_pkg::lfpd_reg_e idx,
                           input logic [lfpd_pkg::CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic load_settings(input setting_kind_e kind);
    logic [lfpd_pkg::CFG_DATA_W-1:0] v [8];
    logic [31:0]                     junk;
    case (kind)
      SET_DEFAULT: v = '{24'd60, 24'd26214, 24'd1311, 24'd66, 24'd85197, 24'd38, 24'd38,
                         24'd150};
      SET_MIN:     v = '{default: '0};
      SET_MAX:     v = '{24'd100, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd100,
                         24'd100, 24'd65535};
      SET_TUNED: begin
        v[0] = lfpd_pkg::CFG_DATA_W'($urandom_range(20, 90));
        v[1] = lfpd_pkg::CFG_DATA_W'($urandom_range(0, 200000));
        v[2] = lfpd_pkg::CFG_DATA_W'($urandom_range(0, 20000));
        v[3] = lfpd_pkg::CFG_DATA_W'($urandom_range(0, 3000));
        v[4] = lfpd_pkg::CFG_DATA_W'($urandom_range(0, 300000));
        v[5] = lfpd_pkg::CFG_DATA_W'($urandom_range(0, 100));
        v[6] = lfpd_pkg::CFG_DATA_W'($urandom_range(0, 100));
        v[7] = lfpd_pkg::CFG_DATA_W'($urandom_range(20, 2500));
        // Junk above the register width must be dropped by the block.
        if ($urandom_range(0, 1) == 1) begin
          junk = $urandom;
          v[0][lfpd_pkg::CFG_DATA_W-1:lfpd_pkg::LEVEL_W] = junk[16:0];
          v[5][lfpd_pkg::CFG_DATA_W-1:lfpd_pkg::LEVEL_W] = junk[31:15];
          v[6][lfpd_pkg::CFG_DATA_W-1:lfpd_pkg::LEVEL_W] = junk[24:8];
          v[7][lfpd_pkg::CFG_DATA_W-1:lfpd_pkg::DIST_W]  = junk[7:0];
        end
      end
      SET_SATURATE: begin
        v[0] = lfpd_pkg::CFG_DATA_W'($urandom_range(0, 100));
        v[1] = 24'hFFFFFF;
        v[2] = lfpd_pkg::CFG_DATA_W'($urandom);
        v[3] = 24'hFFFFFF;
        v[4] = lfpd_pkg::CFG_DATA_W'($urandom);
        v[5] = lfpd_pkg::CFG_DATA_W'($urandom_range(0, 1) * 100);
        v[6] = 24'd100;
        v[7] = lfpd_pkg::CFG_DATA_W'($urandom_range(0, 400));
      end
      default: foreach (v[i]) v[i] = lfpd_pkg::CFG_DATA_W'($urandom);
    endcase
    foreach (v[i]) write_reg(lfpd_pkg::lfpd_reg_e'(i), v[i]);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [lfpd_pkg::LEVEL_W-1:0] pick_level(bit white);
    if ($urandom_range(0, 9) == 0) return lfpd_pkg::LEVEL_W'($urandom_range(0, 127));
    if (white) return ($urandom_range(0, 5) == 0) ? lfpd_pkg::LEVEL_W'($urandom_range(101, 127))
                                                  : lfpd_pkg::LEVEL_W'($urandom_range(41, 100));
    return ($urandom_range(0, 4) == 0) ? lfpd_pkg::BLACK_MAX
                                       : lfpd_pkg::LEVEL_W'($urandom_range(0, 40));
  endfunction

  function automatic logic [lfpd_pkg::DIST_W-1:0] pick_distance(
    logic [lfpd_pkg::DIST_W-1:0] stop
  );
    int s, lo, hi;
    s = int'(stop);
    case ($urandom_range(0, 9))
      0:          begin lo = 0;     hi = s - 1;     end
      1, 2:       begin lo = s;     hi = 2 * s - 1; end
      3, 4:       begin lo = 2 * s; hi = 4 * s - 1; end
      5, 6, 7, 8: begin lo = 4 * s; hi = 65535;     end
      default:    begin lo = 1;     hi = 0;         end
    endcase
    if (hi > 65535) hi = 65535;
    if (hi < lo) return lfpd_pkg::DIST_W'($urandom_range(0, 65535));
    return lfpd_pkg::DIST_W'($urandom_range(hi, lo));
  endfunction

  task automatic directed_samples();
    send_sample(7'd0,   7'd0,   16'd65535);
    send_sample(7'd127, 7'd127, 16'd65535);
    send_sample(7'd40,  7'd40,  16'd600);
    send_sample(7'd41,  7'd41,  16'd599);
    send_sample(7'd41,  7'd40,  16'd300);
    send_sample(7'd40,  7'd41,  16'd299);
    send_sample(7'd100, 7'd0,   16'd150);
    send_sample(7'd0,   7'd100, 16'd149);
    send_sample(7'd127, 7'd0,   16'd0);
    send_sample(7'd100, 7'd100, 16'd65535);
    send_sample(7'd60,  7'd60,  16'd1000);
    repeat (4) send_sample(7'd127, 7'd127, 16'd1000);
    repeat (4) send_sample(7'd0,   7'd0,   16'd1000);
    send_sample(7'd0,   7'd127, 16'd1000);
    send_sample(7'd127, 7'd0,   16'd1000);
    send_sample(7'd85,  7'd20,  16'd450);
    send_sample(7'd20,  7'd85,  16'd899);
  endtask

  task automatic random_samples(input int count, input bit pause_midway);
    logic [1:0] classes;
    int         gap;
    classes = 2'($urandom_range(0, 3));
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) hold_until_empty();
      // The line pattern persists over runs of samples, so the block sees the
      // transitions a robot sees when it drifts across the line.
      if ($urandom_range(0, 3) == 0) classes = 2'($urandom_range(0, 3));
      send_sample(pick_level(classes[1]), pick_level(classes[0]),
                  pick_distance(sb.halt_range));
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 15));
        if (gap > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? 120 : int'($urandom_range(1, 30));
      end
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = lfpd_pkg::REG_TARGET_LEVEL;
    cfg_data           = '0;
    in_bus.valid       = 1'b0;
    in_bus.left_level  = '0;
    in_bus.right_level = '0;
    in_bus.distance    = '0;
    out_bus.ready      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_samples();
    random_samples(ITEMS_PER_PHASE, 1'b1);
    foreach (phase_plan[p]) begin
      hold_until_empty();
      repeat (IDLE_SETTLE) @(negedge clk_i);
      load_settings(phase_plan[p]);
      n_settings++;
      random_samples(ITEMS_PER_PHASE, 1'b0);
    end

    hold_until_empty();
    repeat (IDLE_SETTLE) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d drive results never arrived", sb.pending());
      sb.errors++;
    end

    $display("Checked %0d drive results over %0d register settings, %0d of them stopped.",
             sb.checked, n_settings, sb.n_stopped);
    $display("Braking %0d half / %0d three-quarter, %0d edge-hold steers, %0d outer-gain.",
             sb.n_half, sb.n_three_q, sb.n_edge_hold, sb.n_outer);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
